// ===== hdl/dtmf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DTMF tone generator package
// Transfer types, tone frequencies, key map and the sine table builder.
// ----------------------------------------------------------------------------
package dtmf_pkg;

  typedef struct packed {
    logic [3:0] digit;
    logic       start_req;
  } dtmf_item_t;

  typedef struct packed {
    logic [7:0] sample;
    logic       last;
  } dtmf_result_t;

  localparam logic [10:0] ROW_HZ [4] = '{11'd697, 11'd770, 11'd852, 11'd941};
  localparam logic [10:0] COL_HZ [4] = '{11'd1209, 11'd1336, 11'd1477, 11'd1633};

  // key value to row / column tone; codes above nine act as key zero
  localparam logic [1:0] KEY_ROW [16] = '{
    2'd3, 2'd0, 2'd0, 2'd0, 2'd1, 2'd1, 2'd1, 2'd2,
    2'd2, 2'd2, 2'd3, 2'd3, 2'd3, 2'd3, 2'd3, 2'd3};
  localparam logic [1:0] KEY_COL [16] = '{
    2'd1, 2'd0, 2'd1, 2'd2, 2'd0, 2'd1, 2'd2, 2'd0,
    2'd1, 2'd2, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1};

  localparam logic [5:0]  AMPLITUDE   = 6'd50;
  localparam logic [7:0]  SAMPLE_MAX  = 8'd200;
  localparam logic [63:0] TWO_PI_Q60  = 64'h6487ED5110B4611A;
  localparam int          TAYLOR_TERMS = 12;

  function automatic logic [63:0] mul_q60(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = 128'(a) * 128'(b);
    return p[123:60];
  endfunction

  // round(16384 * sin(2*pi*r / 2^abits)) for 0 <= r <= 2^(abits-2)
  function automatic logic signed [15:0] quarter_sine(input int unsigned r,
                                                      input int unsigned abits);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] rounded;
    int          k;
    x    = (TWO_PI_Q60 >> abits) * 64'(r);
    x2   = mul_q60(x, x);
    term = x;
    sum  = x;
    for (k = 1; k <= TAYLOR_TERMS; k++) begin
      term = mul_q60(term, x2) / 64'((2 * k) * (2 * k + 1));
      if (k % 2 == 1) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    rounded = (sum + (64'd1 << 45)) >> 46;
    return 16'(rounded);
  endfunction

endpackage

// ===== hdl/dtmf_tone_generator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DTMF tone generator
// Dual sine synthesis from two phase accumulators and a quarter sine table.
//
//   channel   handshake                 payload
//   item      item_valid / item_stall   item   (digit, start_req)
//   result    result_valid/result_stall result (sample, last)
//   config    cfg_wen                   cfg_wdata (tone_length)
//
// One item per cycle while the result is not stalled; an item loads the stage register, then the result register.
// Phase and counter update at the input transfer; table lookup and scaling
// sit between the stage register and the result register.
// Reset clears phases, sample index and pipeline; tone_length returns to 800.
// A stalled result holds the pipeline; item_stall rises only when both stages
// are full and the result is stalled.
// ----------------------------------------------------------------------------
module dtmf_tone_generator
  import dtmf_pkg::*;
#(
  parameter int SAMPLE_RATE     = 8000,
  parameter int TABLE_ADDR_BITS = 10
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         item_valid,
  output logic         item_stall,
  input  dtmf_item_t   item,
  output logic         result_valid,
  input  logic         result_stall,
  output dtmf_result_t result,
  input  logic         cfg_wen,
  input  logic [15:0]  cfg_wdata
);

  localparam int AB      = TABLE_ADDR_BITS;
  localparam int QUARTER = 1 << (AB - 2);

  logic [31:0] row_inc [4];
  logic [31:0] col_inc [4];
  logic signed [15:0] qsine [QUARTER + 1];

  for (genvar i = 0; i < 4; i++) begin : g_inc
    localparam logic [31:0] RI =
      32'(((64'(ROW_HZ[i]) << 32) + 64'(SAMPLE_RATE / 2)) / 64'(SAMPLE_RATE));
    localparam logic [31:0] CI =
      32'(((64'(COL_HZ[i]) << 32) + 64'(SAMPLE_RATE / 2)) / 64'(SAMPLE_RATE));
    assign row_inc[i] = RI;
    assign col_inc[i] = CI;
  end

  for (genvar i = 0; i <= QUARTER; i++) begin : g_sine
    localparam logic signed [15:0] SV = quarter_sine(i, AB);
    assign qsine[i] = SV;
  end

  logic [15:0] tone_length;
  logic [31:0] low_phase;
  logic [31:0] high_phase;
  logic [15:0] sample_index;

  logic          s1_valid;
  logic [AB-1:0] s1_addr [2];
  logic          s1_last;

  logic        item_xfer;
  logic        out_load;
  logic        s1_move;
  logic [31:0] low_eff;
  logic [31:0] high_eff;
  logic [15:0] index_eff;

  logic [AB-3:0]       lane_r   [2];
  logic [AB-2:0]       lane_idx [2];
  logic signed [15:0]  lane_sin [2];
  logic signed [17:0]  total;
  logic [22:0]         scaled;
  logic [8:0]          sample_raw;
  dtmf_result_t        result_next;

  assign out_load   = !result_valid || !result_stall;
  assign s1_move    = s1_valid && out_load;
  assign item_stall = s1_valid && !out_load;
  assign item_xfer  = item_valid && !item_stall;

  assign low_eff   = item.start_req ? 32'd0 : low_phase;
  assign high_eff  = item.start_req ? 32'd0 : high_phase;
  assign index_eff = item.start_req ? 16'd0 : sample_index;

  always_ff @(posedge clk) begin
    if (rst) begin
      tone_length <= 16'd800;
    end else if (cfg_wen) begin
      tone_length <= cfg_wdata;
    end
  end

  // advance accumulators and counter on each input transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      low_phase    <= '0;
      high_phase   <= '0;
      sample_index <= '0;
      s1_valid     <= 1'b0;
    end else begin
      if (item_xfer) begin
        low_phase    <= low_eff + row_inc[KEY_ROW[item.digit]];
        high_phase   <= high_eff + col_inc[KEY_COL[item.digit]];
        sample_index <= index_eff + 16'd1;
        s1_valid     <= 1'b1;
      end else if (s1_move) begin
        s1_valid     <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_xfer) begin
      s1_addr[0] <= low_eff[31 -: AB];
      s1_addr[1] <= high_eff[31 -: AB];
      s1_last    <= index_eff == (tone_length - 16'd1);
    end
  end

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      lane_r[l]   = s1_addr[l][AB-3:0];
      lane_idx[l] = s1_addr[l][AB-2] ? ((AB - 1)'(QUARTER) - {1'b0, lane_r[l]})
                                     : {1'b0, lane_r[l]};
      lane_sin[l] = s1_addr[l][AB-1] ? -qsine[lane_idx[l]] : qsine[lane_idx[l]];
    end
    total      = 18'(lane_sin[0]) + 18'(lane_sin[1]) + 18'sd32768;
    scaled     = 23'(total[16:0]) * 23'(AMPLITUDE);
    sample_raw = scaled[22:14];
    result_next.sample = (sample_raw > 9'(SAMPLE_MAX)) ? SAMPLE_MAX : sample_raw[7:0];
    result_next.last   = s1_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_load) begin
      result_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      result <= result_next;
    end
  end

  a_start_low_phase: assert property (@(posedge clk) disable iff (rst)
    item_xfer && item.start_req |=>
      low_phase == row_inc[KEY_ROW[$past(item.digit)]])
    else $error("low phase not restarted from zero");

  a_start_index: assert property (@(posedge clk) disable iff (rst)
    item_xfer && item.start_req |=> sample_index == 16'd1)
    else $error("sample index not restarted");

  a_start_last: assert property (@(posedge clk) disable iff (rst)
    item_xfer && item.start_req |=> s1_last == ($past(tone_length) == 16'd1))
    else $error("last flag wrong on first sample");

  a_sample_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result.sample <= SAMPLE_MAX)
    else $error("sample out of range");

  a_stage_feeds_result: assert property (@(posedge clk) disable iff (rst)
    s1_move |=> result_valid && result.last == $past(s1_last))
    else $error("stage transfer lost");

endmodule
